FILE: rtl/core/hnm_pkg.sv
// Shared types and constants for the height-to-normal-map block.
// No dependencies; imported by the front, queue, back and top modules.
`timescale 1ns / 1ps

package hnm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GAIN         = 2'd2;

  localparam int HGT_W      = 10;  // height sum r+g+b, 0..765
  localparam int QDEPTH     = 4;   // job queue between front and back
  localparam int ROOT_STEPS = 28;
  localparam int DIV_STEPS  = 16;

  // one normal to compute, as handed from front to back
  typedef struct packed {
    logic signed [HGT_W:0] difu;
    logic signed [HGT_W:0] difv;
    logic                  du2;
    logic                  dv2;
    logic                  last;
    logic [9:0]            col;
    logic [9:0]            row;
  } job_t;

  // row slot (modulo three) of a row lying d rows above the row in slot s
  function automatic logic [1:0] slot_back(input logic [1:0] s, input logic [1:0] d);
    logic [1:0] res;
    res = s;
    case ({s, d})
      4'b00_01: res = 2'd2;
      4'b00_10: res = 2'd1;
      4'b01_01: res = 2'd0;
      4'b01_10: res = 2'd2;
      4'b10_01: res = 2'd1;
      4'b10_10: res = 2'd0;
      default:  res = s;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/hnm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hnm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/hnm_front.sv
// Front end: accepts pixels, keeps the three-row height store, lists the
// normals each pixel releases and fetches their neighbour heights.
// Depends on hnm_pkg and hnm_ram.
`timescale 1ns / 1ps

module hnm_front #(
  parameter int MAX_WIDTH  = hnm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hnm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [$clog2(MAX_WIDTH):0]    w_eff,
  input  logic [$clog2(MAX_HEIGHT):0]   h_eff,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_red_in,
  input  logic [7:0]                    in_green_in,
  input  logic [7:0]                    in_blue_in,
  output logic                          push,
  output hnm_pkg::job_t                 push_job,
  input  logic                          q_full
);
  import hnm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(3 * MAX_WIDTH);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] col_r, col_nxt, cur_c_r, cur_c_nxt;
  logic [RW-1:0] row_r, row_nxt, cur_r_r, cur_r_nxt;
  logic [1:0]    slot_r, slot_nxt, cur_s_r, cur_s_nxt;
  logic [3:0]    jobs_r, jobs_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [HGT_W-1:0] hgt_r [4];

  logic          accept, geo_out;
  logic [CW-1:0] c_acc;
  logic [RW-1:0] r_acc;
  logic [1:0]    s_acc;
  logic [3:0]    flags;
  logic [HGT_W-1:0] sum;

  logic [1:0]    jsel;
  logic [3:0]    remaining;
  logic [CW-1:0] x, xa, xb;
  logic [RW-1:0] y;
  logic [1:0]    dy, du_row, va_row, vb_row;
  logic          du2, dv2;
  logic          re;
  logic [AW-1:0] waddr, raddr;
  logic [HGT_W-1:0] rdata;

  function automatic logic [AW-1:0] addr_of(input logic [1:0] s, input logic [CW-1:0] cidx);
    logic [AW-1:0] base;
    case (s)
      2'd1:    base = AW'(MAX_WIDTH);
      2'd2:    base = AW'(2 * MAX_WIDTH);
      default: base = '0;
    endcase
    return base + AW'(cidx);
  endfunction

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign sum      = HGT_W'(in_red_in) + HGT_W'(in_green_in) + HGT_W'(in_blue_in);

  // pixel position, restarting the frame if geometry shrank under the counters
  always_comb begin
    geo_out = ({1'b0, col_r} >= w_eff) || ({1'b0, row_r} >= h_eff);
    c_acc   = geo_out ? '0 : col_r;
    r_acc   = geo_out ? '0 : row_r;
    s_acc   = geo_out ? 2'd0 : slot_r;
    flags[0] = (r_acc != '0) && (c_acc != '0);
    flags[1] = (r_acc != '0) && ({1'b0, c_acc} == w_eff - 1'b1);
    flags[2] = ({1'b0, r_acc} == h_eff - 1'b1) && (c_acc != '0);
    flags[3] = ({1'b0, r_acc} == h_eff - 1'b1) && ({1'b0, c_acc} == w_eff - 1'b1);
    waddr   = addr_of(s_acc, c_acc);
  end

  // geometry of the job being fetched
  always_comb begin
    if (jobs_r[0])      jsel = 2'd0;
    else if (jobs_r[1]) jsel = 2'd1;
    else if (jobs_r[2]) jsel = 2'd2;
    else                jsel = 2'd3;
    remaining = jobs_r & ~(4'b0001 << jsel);
    x  = (jsel == 2'd0 || jsel == 2'd2) ? cur_c_r - 1'b1 : CW'(w_eff - 1'b1);
    dy = (jsel == 2'd0 || jsel == 2'd1) ? 2'd1 : 2'd0;
    y  = cur_r_r - RW'(dy);
    du_row = slot_back(cur_s_r, dy);
    if (x == '0) begin
      xa = '0;  xb = CW'(1);  du2 = 1'b0;
    end else if (({1'b0, x} + 1'b1) < w_eff) begin
      xa = x - 1'b1;  xb = x + 1'b1;  du2 = 1'b1;
    end else begin
      xa = x - 1'b1;  xb = x;  du2 = 1'b0;
    end
    if (y == '0) begin
      va_row = slot_back(cur_s_r, dy);
      vb_row = slot_back(cur_s_r, dy - 2'd1);
      dv2 = 1'b0;
    end else if (({1'b0, y} + 1'b1) < h_eff) begin
      va_row = slot_back(cur_s_r, dy + 2'd1);
      vb_row = slot_back(cur_s_r, dy - 2'd1);
      dv2 = 1'b1;
    end else begin
      va_row = slot_back(cur_s_r, dy + 2'd1);
      vb_row = slot_back(cur_s_r, dy);
      dv2 = 1'b0;
    end
    case (phase_r)
      3'd0:    raddr = addr_of(du_row, xa);
      3'd1:    raddr = addr_of(du_row, xb);
      3'd2:    raddr = addr_of(va_row, x);
      default: raddr = addr_of(vb_row, x);
    endcase
    re = busy_r && (phase_r <= 3'd3);
  end

  always_comb begin
    push_job.difu = $signed({1'b0, hgt_r[0]}) - $signed({1'b0, hgt_r[1]});
    push_job.difv = $signed({1'b0, hgt_r[2]}) - $signed({1'b0, hgt_r[3]});
    push_job.du2  = du2;
    push_job.dv2  = dv2;
    push_job.last = (remaining == 4'd0);
    push_job.col  = 10'(x);
    push_job.row  = 10'(y);
    push = busy_r && (phase_r == 3'd5) && !q_full;
  end

  always_comb begin
    busy_nxt  = busy_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    slot_nxt  = slot_r;
    cur_c_nxt = cur_c_r;
    cur_r_nxt = cur_r_r;
    cur_s_nxt = cur_s_r;
    jobs_nxt  = jobs_r;
    phase_nxt = phase_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = 2'd0;
    end else if (accept) begin
      cur_c_nxt = c_acc;
      cur_r_nxt = r_acc;
      cur_s_nxt = s_acc;
      jobs_nxt  = flags;
      busy_nxt  = |flags;
      phase_nxt = 3'd0;
      if ({1'b0, c_acc} == w_eff - 1'b1) begin
        col_nxt = '0;
        if ({1'b0, r_acc} == h_eff - 1'b1) begin
          row_nxt  = '0;
          slot_nxt = 2'd0;
        end else begin
          row_nxt  = r_acc + 1'b1;
          slot_nxt = (s_acc == 2'd2) ? 2'd0 : s_acc + 2'd1;
        end
      end else begin
        col_nxt  = c_acc + 1'b1;
        row_nxt  = r_acc;
        slot_nxt = s_acc;
      end
    end else if (busy_r) begin
      if (phase_r != 3'd5) begin
        phase_nxt = phase_r + 3'd1;
      end else if (!q_full) begin
        jobs_nxt  = remaining;
        phase_nxt = 3'd0;
        busy_nxt  = (remaining != 4'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= 2'd0;
      jobs_r  <= 4'd0;
      phase_r <= 3'd0;
    end else begin
      busy_r  <= busy_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      slot_r  <= slot_nxt;
      jobs_r  <= jobs_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_c_r <= cur_c_nxt;
    cur_r_r <= cur_r_nxt;
    cur_s_r <= cur_s_nxt;
    if (busy_r && phase_r >= 3'd1 && phase_r <= 3'd4) begin
      hgt_r[2'(phase_r - 3'd1)] <= rdata;
    end
  end

  hnm_ram #(
    .WIDTH(HGT_W),
    .DEPTH(3 * MAX_WIDTH)
  ) u_store (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr),
    .wdata(sum),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

FILE: rtl/core/hnm_queue.sv
// Short job queue between front and back ends.
// Depends on hnm_pkg.
`timescale 1ns / 1ps

module hnm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hnm_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output hnm_pkg::job_t pop_job,
  output logic          empty
);
  import hnm_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t        slots_r [QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (PW + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slots_r[rd_r];

  always_comb begin
    wr_nxt  = (push && !full) ? wr_r + 1'b1 : wr_r;
    rd_nxt  = (pop && !empty) ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (PW + 1)'(push && !full) - (PW + 1)'(pop && !empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_r[wr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/hnm_back.sv
// Back end: turns one job into an encoded normal with a shared multiplier,
// a bit-serial square root and a restoring divider. Holds the output register.
// Depends on hnm_pkg.
`timescale 1ns / 1ps

module hnm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] gain,
  input  logic               q_empty,
  input  hnm_pkg::job_t      q_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_normal_red,
  output logic [7:0]         out_normal_green,
  output logic [7:0]         out_normal_blue,
  output logic [9:0]         out_col_out,
  output logic [9:0]         out_row_out,
  output logic               out_run_last
);
  import hnm_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_PROD  = 3'd1;
  localparam logic [2:0] B_SQ    = 3'd2;
  localparam logic [2:0] B_ROOT  = 3'd3;
  localparam logic [2:0] B_DINIT = 3'd4;
  localparam logic [2:0] B_DIV   = 3'd5;
  localparam logic [2:0] B_DONE  = 3'd6;

  logic [2:0]  st_r;
  logic [4:0]  cnt_r;
  logic [1:0]  comp_r;
  job_t        job_r;
  logic        xneg_r, yneg_r;
  logic [27:0] mx_r, my_r;
  logic [11:0] z_r;
  logic [55:0] acc_r, s_r, rt_r, bit_r;
  logic [27:0] len_r, rem_r;
  logic [15:0] q_r;
  logic [7:0]  byte_r [3];
  logic        out_valid_r;

  logic signed [26:0] px, py;
  logic signed [27:0] sx, sy;
  logic [27:0] sq_op;
  logic [55:0] sq;
  logic [55:0] trial;
  logic [27:0] mag;
  logic        nbit, ge;
  logic [28:0] rem2;
  logic [15:0] qfin, qc;
  logic [16:0] biased;
  logic [24:0] scaled;
  logic        load_out;

  assign pop       = (st_r == B_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign load_out  = (st_r == B_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    px = job_r.difu * gain;
    py = job_r.difv * gain;
    sx = job_r.dv2 ? (28'(px) <<< 1) : 28'(px);
    sy = job_r.du2 ? (28'(py) <<< 1) : 28'(py);
    case (cnt_r[1:0])
      2'd0:    sq_op = mx_r;
      2'd1:    sq_op = my_r;
      default: sq_op = 28'(z_r);
    endcase
    sq    = sq_op * sq_op;
    trial = rt_r + bit_r;
    case (comp_r)
      2'd0:    mag = mx_r;
      2'd1:    mag = my_r;
      default: mag = 28'(z_r);
    endcase
    nbit = (cnt_r == 5'd0) ? mag[0] : 1'b0;
    rem2 = {rem_r, nbit};
    ge   = rem2 >= {1'b0, len_r};
    qfin = {q_r[14:0], ge};
    qc   = (qfin > 16'd32768) ? 16'd32768 : qfin;
    // red carries minus nx, green plus ny, blue plus nz
    case (comp_r)
      2'd0:    biased = xneg_r ? 17'd32768 + 17'(qc) : 17'd32768 - 17'(qc);
      2'd1:    biased = yneg_r ? 17'd32768 - 17'(qc) : 17'd32768 + 17'(qc);
      default: biased = 17'd32768 + 17'(qc);
    endcase
    scaled = {biased, 8'd0} - 25'(biased);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        B_IDLE:  if (!q_empty) st_r <= B_PROD;
        B_PROD:  st_r <= B_SQ;
        B_SQ:    if (cnt_r == 5'd2) st_r <= B_ROOT;
        B_ROOT:  if (cnt_r == 5'(ROOT_STEPS - 1)) st_r <= B_DINIT;
        B_DINIT: st_r <= B_DIV;
        B_DIV: begin
          if (cnt_r == 5'(DIV_STEPS - 1)) begin
            st_r <= (comp_r == 2'd2) ? B_DONE : B_DINIT;
          end
        end
        B_DONE:  if (load_out) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        job_r <= q_job;
        cnt_r <= 5'd0;
      end
      B_PROD: begin
        // X = -sx, Y = -sy
        xneg_r <= !sx[27] && (sx != '0);
        yneg_r <= !sy[27] && (sy != '0);
        mx_r   <= sx[27] ? 28'(-sx) : 28'(sx);
        my_r   <= sy[27] ? 28'(-sy) : 28'(sy);
        z_r    <= 12'd256 << (2'(job_r.du2) + 2'(job_r.dv2));
        acc_r  <= '0;
        cnt_r  <= 5'd0;
      end
      B_SQ: begin
        if (cnt_r == 5'd2) begin
          s_r   <= acc_r + sq;
          rt_r  <= '0;
          bit_r <= 56'd1 << (2 * (ROOT_STEPS - 1));
          cnt_r <= 5'd0;
        end else begin
          acc_r <= acc_r + sq;
          cnt_r <= cnt_r + 5'd1;
        end
      end
      B_ROOT: begin
        if (s_r >= trial) begin
          s_r  <= s_r - trial;
          rt_r <= (rt_r >> 1) + bit_r;
        end else begin
          rt_r <= rt_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        comp_r <= 2'd0;
        if (cnt_r == 5'(ROOT_STEPS - 1)) begin
          len_r <= (s_r >= trial) ? 28'((rt_r >> 1) + bit_r) : 28'(rt_r >> 1);
        end
      end
      B_DINIT: begin
        rem_r <= mag >> 1;
        q_r   <= '0;
        cnt_r <= 5'd0;
      end
      B_DIV: begin
        rem_r <= ge ? 28'(rem2 - {1'b0, len_r}) : rem2[27:0];
        q_r   <= qfin;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          byte_r[comp_r] <= scaled[23:16];
          comp_r <= comp_r + 2'd1;
        end
      end
      default: begin
        cnt_r <= 5'd0;
      end
    endcase
    if (load_out) begin
      out_normal_red   <= byte_r[0];
      out_normal_green <= byte_r[1];
      out_normal_blue  <= byte_r[2];
      out_col_out      <= job_r.col;
      out_row_out      <= job_r.row;
      out_run_last     <= job_r.last;
    end
  end

endmodule

FILE: rtl/core/height_to_normal_map_top.sv
// Height map to normal map converter, top level: config registers, front end,
// job queue and back end. Depends on hnm_pkg, hnm_front, hnm_queue, hnm_back.
//
// Pixels stream in row-major; each item's height is red+green+blue. Normals
// come out one row and one column behind the input, each tagged with its
// column and row, with run_last on the final normal a pixel releases (a
// frame's last pixel releases four). Width and height are saturated into
// 2..MAX_WIDTH / 2..MAX_HEIGHT; any register write restarts the frame and must
// only be issued while idle. The front takes a pixel and then, for each
// released normal, reads four neighbour heights from the single-read-port
// row store and pushes the job, waiting while the job queue is full. The back
// works on one normal at a time: it pops the job, forms the products, sums
// the three squares, runs a 28-step bit-serial square root and three
// restoring divisions (load plus 16 steps each), and loads the output register
// before it takes the next job. The row store needs no clearing pass after
// reset: within a frame it is always written before it is read.
`timescale 1ns / 1ps

module height_to_normal_map_top #(
  parameter int MAX_WIDTH  = hnm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hnm_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_normal_red,
  output logic [7:0]  out_normal_green,
  output logic [7:0]  out_normal_blue,
  output logic [9:0]  out_col_out,
  output logic [9:0]  out_row_out,
  output logic        out_run_last
);
  import hnm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [10:0]        width_r, height_r;
  logic signed [15:0] gain_r;
  logic               restart;
  logic [CW:0]        w_eff;
  logic [RW:0]        h_eff;

  logic  push, pop, q_full, q_empty;
  job_t  push_job, pop_job;

  // a write to any listed register restarts the frame
  assign restart = cfg_wr_en &&
                   (cfg_index inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_GAIN});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
      gain_r   <= 16'sd256;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[10:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[10:0];
        CFG_GAIN:         gain_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // saturate geometry into the supported range
  always_comb begin
    if (32'(width_r) < 32'd2)              w_eff = (CW + 1)'(2);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = (CW + 1)'(MAX_WIDTH);
    else                                    w_eff = (CW + 1)'(width_r);
    if (32'(height_r) < 32'd2)               h_eff = (RW + 1)'(2);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h_eff = (RW + 1)'(MAX_HEIGHT);
    else                                      h_eff = (RW + 1)'(height_r);
  end

  hnm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_red_in  (in_red_in),
    .in_green_in(in_green_in),
    .in_blue_in (in_blue_in),
    .push       (push),
    .push_job   (push_job),
    .q_full     (q_full)
  );

  hnm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  hnm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .gain            (gain_r),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_normal_red  (out_normal_red),
    .out_normal_green(out_normal_green),
    .out_normal_blue (out_normal_blue),
    .out_col_out     (out_col_out),
    .out_row_out     (out_row_out),
    .out_run_last    (out_run_last)
  );

endmodule

FILE: rtl/core/hnm_checker.sv
// Port-level checks for the height-to-normal-map top level, bound to it.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module hnm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_normal_blue
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // reset leaves the front ready for a pixel
  assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  // the z component is never negative, so blue never drops below mid-scale
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_blue >= 8'd127)
    else $error("blue channel below mid-scale");

endmodule

bind height_to_normal_map_top hnm_checker u_hnm_checker (.*);
